// ----- sv/bffa_pkg.sv -----
// bffa_pkg: shared constants, codes, state type and bit-search helpers for
// the bitmap first-fit allocator; depends on nothing.
package bffa_pkg;

   localparam int MAP_BITS_DEF = 1024;
   localparam int WORD_W       = 32;
   localparam int BIT_W        = 5;
   localparam int OP_W         = 2;
   localparam int IDX_W        = 32;
   localparam int RUN_W        = 11;
   localparam int STATUS_W     = 2;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;
   localparam int MAP_BYTES_W  = 8;

   localparam logic [MAP_BYTES_W-1:0] MAP_BYTES_RST = 8'd128;

   // request kinds
   localparam logic [OP_W-1:0] OP_TEST  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd2;

   // register indexes on the csr port
   localparam logic REG_BASE_INDEX = 1'b0;
   localparam logic REG_MAP_BYTES  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_WAIT,
      ST_SCAN,
      ST_MARK,
      ST_FINISH
   } state_type;

   // index of the lowest set bit, WORD_W when none is set
   function automatic logic [BIT_W:0] lowest_set(input logic [WORD_W-1:0] v);
      logic [BIT_W:0] r;
      r = (BIT_W+1)'(WORD_W);
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) r = (BIT_W+1)'(i);
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_W; i++) begin
         r[i] = v[WORD_W-1-i];
      end
      return r;
   endfunction

endpackage

// ----- sv/bitmap_first_fit_allocator.sv -----
// bitmap_first_fit_allocator: page-busy bitmap held in a word ram, with bit
// test, bit write and first-fit run allocation; uses bffa_pkg and bffa_ram.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | op, index, write_value, run_length
//   rsp     | out       | rsp_valid/rsp_stall  | status, bit_value, start_index
//   csr     | in/out    | apb psel/penable     | base_index @0, map_bytes @4
//
// test and write go through decode, one ram read, write-back (write only)
// and the result register, skipping the read when out of range.
// allocate goes through decode, S words scanned (one 32-bit ram word a
// cycle, up to bits_in_use/32 rounded up), M words marked busy (one write
// a cycle) and the result register; a zero run length or an empty map
// gives S = M = 0. after reset the ram is cleared one word a cycle, with
// req_stall high; csr writes are taken throughout.
// a finished result waits in the output register, so rsp_stall only holds
// back a request that is done and waiting for that register.
module bitmap_first_fit_allocator
   import bffa_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_op,
   input  logic [IDX_W-1:0]       req_index,
   input  logic                   req_write_value,
   input  logic [RUN_W-1:0]       req_run_length,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_bit_value,
   output logic [IDX_W-1:0]       rsp_start_index,
   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   localparam int WORDS   = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int POS_W   = WORD_AW + BIT_W;
   localparam int N_W     = (POS_W + 1 > RUN_W) ? POS_W + 1 : RUN_W;

   localparam logic [WORD_AW-1:0] LAST_RAM_WORD = WORD_AW'(WORDS - 1);
   localparam logic [WORD_W-1:0]  ONES          = {WORD_W{1'b1}};

   state_type state_ff, state_in;

   logic [OP_W-1:0]        op_ff, op_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   wv_ff, wv_in;
   logic [RUN_W-1:0]       want_ff, want_in;

   logic [WORD_AW-1:0]     word_ff, word_in;
   logic [WORD_AW-1:0]     scan_word_ff, scan_word_in;
   logic [RUN_W-1:0]       carry_ff, carry_in;
   logic [WORD_W-1:0]      saved_ff, saved_in;
   logic [WORD_W-1:0]      end_data_ff, end_data_in;
   logic [POS_W-1:0]       start_pos_ff, start_pos_in;
   logic [BIT_W-1:0]       end_bit_ff, end_bit_in;
   logic [BIT_W-1:0]       tgt_bit_ff, tgt_bit_in;

   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   res_bit_ff, res_bit_in;
   logic [IDX_W-1:0]       res_start_ff, res_start_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                   rsp_bit_ff, rsp_bit_in;
   logic [IDX_W-1:0]       rsp_start_ff, rsp_start_in;

   logic [IDX_W-1:0]       base_ff, base_in;
   logic [MAP_BYTES_W-1:0] map_bytes_ff, map_bytes_in;

   logic                   ram_wr_en;
   logic [WORD_AW-1:0]     ram_wr_addr;
   logic [WORD_W-1:0]      ram_wr_data;
   logic [WORD_AW-1:0]     ram_rd_addr;
   logic [WORD_W-1:0]      ram_rd_data;

   // bits in use and where the scan ends
   logic [N_W-1:0]         map_bits_req;
   logic [N_W-1:0]         bits_used;
   logic [N_W-1:0]         bits_used_m1;
   logic [WORD_AW-1:0]     last_word;
   logic [BIT_W-1:0]       last_bits;

   // request decode
   logic [IDX_W-1:0]       pos_full;
   logic                   in_range;

   // scan datapath
   logic [WORD_W-1:0]      busy_m;
   logic                   all_free;
   logic [BIT_W:0]         lead_free;
   logic [BIT_W:0]         trail_free;
   logic [WORD_W:0]        win_f;
   logic [WORD_W:0]        win_r;
   logic [BIT_W:0]         win_q;
   logic                   win_ok;
   logic                   fit_carry;
   logic                   found;
   logic                   scan_last;
   logic [POS_W-1:0]       found_pos;
   logic [BIT_W-1:0]       found_end;
   logic [RUN_W-1:0]       carry_gap;

   // mark datapath
   logic [WORD_AW-1:0]     start_word;
   logic [BIT_W-1:0]       mark_lo;
   logic [BIT_W-1:0]       mark_hi;
   logic [WORD_W-1:0]      mark_mask;
   logic [WORD_W-1:0]      mark_old;

   logic                   out_free;
   logic                   csr_wr;

   bffa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- config

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      base_in      = base_ff;
      map_bytes_in = map_bytes_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_BASE_INDEX: base_in      = csr_pwdata;
            REG_MAP_BYTES:  map_bytes_in = csr_pwdata[MAP_BYTES_W-1:0];
            default:        base_in      = base_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_BASE_INDEX: csr_prdata = base_ff;
         REG_MAP_BYTES:  csr_prdata = CSR_DW'(map_bytes_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign map_bits_req = N_W'(map_bytes_ff) << 3;
   assign bits_used    = (map_bits_req < N_W'(MAP_BITS)) ? map_bits_req : N_W'(MAP_BITS);
   assign bits_used_m1 = bits_used - N_W'(1);
   assign last_word    = bits_used_m1[BIT_W +: WORD_AW];
   assign last_bits    = bits_used[BIT_W-1:0];

   // ---------------------------------------------------------------- decode

   assign pos_full = idx_ff - base_ff;
   assign in_range = (idx_ff >= base_ff) && (pos_full < IDX_W'(bits_used));

   // ---------------------------------------------------------------- scan

   always_comb begin
      // bits past the end of the map count as busy
      if ((scan_word_ff == last_word) && (last_bits != '0)) begin
         busy_m = ram_rd_data | (ONES << last_bits);
      end else begin
         busy_m = ram_rd_data;
      end
   end

   assign all_free   = (busy_m == '0);
   assign lead_free  = lowest_set(busy_m);
   assign trail_free = lowest_set(bit_reverse(busy_m));

   // win_r[q] set when want_ff free bits start at q inside this word,
   // built by doubling runs of free bits over the binary digits of want
   always_comb begin
      win_f = {1'b0, ~busy_m};
      win_r = '1;
      for (int k = 0; k < BIT_W; k++) begin
         if (want_ff[k]) win_r = win_f & (win_r >> (1 << k));
         win_f = win_f & (win_f >> (1 << k));
      end
   end

   assign win_q     = lowest_set(win_r[WORD_W-1:0]);
   assign win_ok    = (want_ff[RUN_W-1:BIT_W] == '0) && (win_r[WORD_W-1:0] != '0);
   assign fit_carry = ((RUN_W+1)'(carry_ff) + (RUN_W+1)'(lead_free)) >= (RUN_W+1)'(want_ff);
   assign found     = fit_carry || win_ok;
   assign scan_last = (scan_word_ff == last_word);
   assign carry_gap = want_ff - carry_ff - RUN_W'(1);

   always_comb begin
      // a run carried in from earlier words ends first, so it wins
      if (fit_carry) begin
         found_pos = {scan_word_ff, BIT_W'(0)} - POS_W'(carry_ff);
         found_end = carry_gap[BIT_W-1:0];
      end else begin
         found_pos = {scan_word_ff, win_q[BIT_W-1:0]};
         found_end = win_q[BIT_W-1:0] + want_ff[BIT_W-1:0] - BIT_W'(1);
      end
   end

   // ---------------------------------------------------------------- mark

   assign start_word = start_pos_ff[POS_W-1:BIT_W];
   assign mark_lo    = (word_ff == start_word) ? start_pos_ff[BIT_W-1:0] : '0;
   assign mark_hi    = (word_ff == scan_word_ff) ? end_bit_ff : BIT_W'(WORD_W - 1);
   assign mark_mask  = (ONES << mark_lo) & (ONES >> (BIT_W'(WORD_W - 1) - mark_hi));

   always_comb begin
      // words inside the run were all free, so only its end words keep bits
      if (word_ff == scan_word_ff) begin
         mark_old = end_data_ff;
      end else if (word_ff == start_word) begin
         mark_old = saved_ff;
      end else begin
         mark_old = '0;
      end
   end

   // ---------------------------------------------------------------- control

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (word_ff == LAST_RAM_WORD) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (op_ff) inside
               OP_TEST, OP_WRITE: state_in = in_range ? ST_WAIT : ST_FINISH;
               OP_ALLOC: begin
                  if ((want_ff == '0) || (bits_used == '0)) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_MARK;
            end else if (scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_MARK: begin
            if (word_ff == scan_word_ff) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      idx_in        = idx_ff;
      wv_in         = wv_ff;
      want_in       = want_ff;
      word_in       = word_ff;
      scan_word_in  = scan_word_ff;
      carry_in      = carry_ff;
      saved_in      = saved_ff;
      end_data_in   = end_data_ff;
      start_pos_in  = start_pos_ff;
      end_bit_in    = end_bit_ff;
      tgt_bit_in    = tgt_bit_ff;
      res_status_in = res_status_ff;
      res_bit_in    = res_bit_ff;
      res_start_in  = res_start_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bit_in    = rsp_bit_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = word_ff;
      ram_wr_data   = '0;
      ram_rd_addr   = pos_full[BIT_W +: WORD_AW];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            word_in   = word_ff + WORD_AW'(1);
         end
         ST_IDLE: begin
            op_in   = req_op;
            idx_in  = req_index;
            wv_in   = req_write_value;
            want_in = req_run_length;
         end
         ST_DECODE: begin
            word_in       = pos_full[BIT_W +: WORD_AW];
            tgt_bit_in    = pos_full[BIT_W-1:0];
            scan_word_in  = '0;
            carry_in      = '0;
            res_status_in = STATUS_OK;
            res_bit_in    = 1'b0;
            res_start_in  = '0;
            case (op_ff) inside
               OP_TEST, OP_WRITE: begin
                  if (!in_range) res_status_in = STATUS_RANGE;
               end
               OP_ALLOC: begin
                  ram_rd_addr = '0;
                  if ((want_ff == '0) || (bits_used == '0)) res_status_in = STATUS_NOFIT;
               end
               default: res_status_in = STATUS_OK;
            endcase
         end
         ST_WAIT: begin
            if (op_ff == OP_TEST) begin
               res_bit_in = ram_rd_data[tgt_bit_ff];
            end else begin
               ram_wr_en              = 1'b1;
               ram_wr_data            = ram_rd_data;
               ram_wr_data[tgt_bit_ff] = wv_ff;
            end
         end
         ST_SCAN: begin
            ram_rd_addr = scan_word_ff + WORD_AW'(1);
            if (found) begin
               start_pos_in = found_pos;
               end_bit_in   = found_end;
               end_data_in  = ram_rd_data;
               word_in      = found_pos[POS_W-1:BIT_W];
            end else if (scan_last) begin
               res_status_in = STATUS_NOFIT;
            end else begin
               scan_word_in = scan_word_ff + WORD_AW'(1);
               // a fresh run begins in this word unless a run runs through it
               if (!all_free || (carry_ff == '0)) saved_in = ram_rd_data;
               carry_in = all_free ? (carry_ff + RUN_W'(WORD_W)) : RUN_W'(trail_free);
            end
         end
         ST_MARK: begin
            ram_wr_en    = 1'b1;
            ram_wr_data  = mark_old | mark_mask;
            word_in      = word_ff + WORD_AW'(1);
            res_start_in = base_ff + IDX_W'(start_pos_ff);
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bit_in    = res_bit_ff;
               rsp_start_in  = res_start_ff;
            end
         end
         default: ram_wr_en = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- registers

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         map_bytes_ff <= MAP_BYTES_RST;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         map_bytes_ff <= map_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      wv_ff         <= wv_in;
      want_ff       <= want_in;
      scan_word_ff  <= scan_word_in;
      carry_ff      <= carry_in;
      saved_ff      <= saved_in;
      end_data_ff   <= end_data_in;
      start_pos_ff  <= start_pos_in;
      end_bit_ff    <= end_bit_in;
      tgt_bit_ff    <= tgt_bit_in;
      res_status_ff <= res_status_in;
      res_bit_ff    <= res_bit_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_start_ff  <= rsp_start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_bit_value   = rsp_bit_ff;
   assign rsp_start_index = rsp_start_ff;

   // ---------------------------------------------------------------- checks

   // a result only appears out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish step");

   // the map is only written by the clear sweep, a bit write or run marking
   a_ram_write_owner: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR) || (state_ff == ST_MARK) ||
                    ((state_ff == ST_WAIT) && (op_ff == OP_WRITE)))
      else $error("map written outside clear, write or mark");

   // the carried free run never reaches the wanted length unnoticed
   a_carry_below_want: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (carry_ff < want_ff))
      else $error("carried run reached the wanted length");

   a_scan_in_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_word_ff <= last_word))
      else $error("scan ran past the last word in use");

   // marking walks from the run's first word up to the word where it ended
   a_mark_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (word_ff <= scan_word_ff) && (word_ff >= start_word))
      else $error("marking outside the found run");

endmodule

// ----- sv/bffa_ram.sv -----
// bffa_ram: generic simple dual-port ram, one write and one registered read
// port per cycle, read returns old data on a same-address write; no imports.
module bffa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- test/bffa_checker.sv -----
// bffa_checker: watches the request, result and csr ports of the bitmap
// first-fit allocator, keeps its own copy of the page map and checks results
// in order; uses bffa_pkg
module bffa_checker
   import bffa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [OP_W-1:0]        req_op,
   input  logic [IDX_W-1:0]       req_index,
   input  logic                   req_write_value,
   input  logic [RUN_W-1:0]       req_run_length,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [STATUS_W-1:0]    rsp_status,
   input  logic                   rsp_bit_value,
   input  logic [IDX_W-1:0]       rsp_start_index,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   input  logic                   csr_pready,
   output int                     fail_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                bit_value;
      logic [IDX_W-1:0]    start_index;
   } outcome_type;

   logic [MAP_BITS_DEF-1:0] page_busy;
   logic [IDX_W-1:0]        base_cfg;
   logic [MAP_BYTES_W-1:0]  bytes_cfg;
   outcome_type             outcome_q[$];

   // works out the result of one request and updates the page map
   task automatic serve_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic wv, input logic [RUN_W-1:0] want,
                                output outcome_type res);
      int unsigned span, run, pos, first;
      logic [IDX_W-1:0] offs;
      bit hit;
      res = '{STATUS_OK, 1'b0, '0};
      span = int'(bytes_cfg) * 8;
      if (span > MAP_BITS_DEF) span = MAP_BITS_DEF;
      offs = idx - base_cfg;
      case (op) inside
         OP_TEST, OP_WRITE: begin
            if (idx < base_cfg || offs >= span) res.status = STATUS_RANGE;
            else if (op == OP_TEST) res.bit_value = page_busy[offs];
            else page_busy[offs] = wv;
         end
         OP_ALLOC: begin
            hit = 1'b0;
            run = 0;
            first = 0;
            if (want != 0) begin
               for (pos = 0; pos < span && !hit; pos++) begin
                  run = page_busy[pos] ? 0 : run + 1;
                  if (run == want) begin
                     hit = 1'b1;
                     first = pos + 1 - want;
                  end
               end
            end
            if (hit) begin
               for (pos = first; pos < first + want; pos++) page_busy[pos] = 1'b1;
               res.start_index = base_cfg + IDX_W'(first);
            end else begin
               res.status = STATUS_NOFIT;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      outcome_type predicted, oldest;
      if (reset) begin
         page_busy = '0;
         base_cfg = '0;
         bytes_cfg = MAP_BYTES_RST;
         outcome_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_MAP_BYTES) bytes_cfg = csr_pwdata[MAP_BYTES_W-1:0];
            else base_cfg = csr_pwdata[IDX_W-1:0];
         end
         // a result can never belong to a request accepted at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: result with nothing due: status %0d bit %0d start %h",
                        $time, rsp_status, rsp_bit_value, rsp_start_index);
               fail_count++;
            end else begin
               oldest = outcome_q.pop_front();
               if (rsp_status !== oldest.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, oldest.status, rsp_status);
                  fail_count++;
               end
               if (rsp_bit_value !== oldest.bit_value) begin
                  $display("%0t: bit_value expected %0d, got %0d",
                           $time, oldest.bit_value, rsp_bit_value);
                  fail_count++;
               end
               if (rsp_start_index !== oldest.start_index) begin
                  $display("%0t: start_index expected %h, got %h",
                           $time, oldest.start_index, rsp_start_index);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            serve_request(req_op, req_index, req_write_value, req_run_length, predicted);
            outcome_q.push_back(predicted);
         end
      end
      outstanding <= outcome_q.size();
   end

endmodule

// ----- test/tb.sv -----
// tb: top of the bitmap first-fit allocator bench; drives requests, csr
// writes and result stalls, and gives the verdict from bffa_checker
// uses bffa_pkg, bffa_checker and the allocator rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bffa_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   // covers the longest allocate: 32 words scanned and 32 words marked
   localparam int SETTLE_CYCLES = 80;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op = '0;
   logic [IDX_W-1:0]     req_index = '0;
   logic                 req_write_value = 1'b0;
   logic [RUN_W-1:0]     req_run_length = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_bit_value;
   logic [IDX_W-1:0]     rsp_start_index;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]    csr_paddr = '0;
   logic [CSR_DW-1:0]    csr_pwdata = '0;
   logic [CSR_DW-1:0]    csr_prdata;
   logic                 csr_pready;

   int                   fail_count;
   int                   outstanding;
   int                   cycles = 0;
   int                   items_sent = 0;
   int                   sender_idle_pct = 0;
   int                   stall_pct = 0;
   logic [IDX_W-1:0]     base_now = '0;
   int unsigned          span = MAP_BITS_DEF;

   bitmap_first_fit_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_index(req_index), .req_write_value(req_write_value),
      .req_run_length(req_run_length),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_bit_value(rsp_bit_value), .rsp_start_index(rsp_start_index),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   bffa_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_index(req_index), .req_write_value(req_write_value),
      .req_run_length(req_run_length),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_bit_value(rsp_bit_value), .rsp_start_index(rsp_start_index),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[bitmap_first_fit_allocator] ERROR");
         $finish;
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input logic wv, input logic [RUN_W-1:0] len);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_index <= idx;
      req_write_value <= wv;
      req_run_length <= len;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // setup then access; the caller drops psel after the last write
   task automatic write_csr(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // hold off requests until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // an index that usually misses the map in use
   function automatic logic [IDX_W-1:0] stray_index();
      case ($urandom_range(2))
         0: return (base_now != 0) ? IDX_W'($urandom_range(base_now - 1)) : IDX_W'($urandom);
         1: return base_now + IDX_W'(span) + IDX_W'($urandom_range(64));
         default: return IDX_W'($urandom);
      endcase
   endfunction

   task automatic random_request();
      int unsigned pick, pos, len, r;
      logic [IDX_W-1:0] idx;
      pick = $urandom_range(99);
      pos = (span != 0) ? $urandom_range(span - 1) : 0;
      idx = (span != 0 && $urandom_range(99) < 85) ? base_now + IDX_W'(pos) : stray_index();
      if (pick < 12 && span != 0) begin
         // free a stretch of pages, then ask for a run of that length
         len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
         for (int k = 0; k < len; k++)
            send_request(OP_WRITE, base_now + IDX_W'((pos + k) % span), 1'b0,
                         RUN_W'($urandom));
         send_request(OP_ALLOC, IDX_W'($urandom), 1'($urandom), RUN_W'(len));
      end else if (pick < 45) begin
         r = $urandom_range(99);
         if (r < 70) len = $urandom_range(8, 1);
         else if (r < 85) len = $urandom_range(64, 9);
         else if (r < 92) len = $urandom_range(1024, 65);
         else if (r < 96) len = 0;
         else len = $urandom_range(2047);
         send_request(OP_ALLOC, IDX_W'($urandom), 1'($urandom), RUN_W'(len));
      end else if (pick < 75) begin
         send_request(OP_WRITE, idx, $urandom_range(99) < 40, RUN_W'($urandom));
      end else if (pick < 95) begin
         send_request(OP_TEST, idx, 1'($urandom), RUN_W'($urandom));
      end else begin
         send_request(OP_NONE, IDX_W'($urandom), 1'($urandom), RUN_W'($urandom));
      end
   endtask

   task automatic run_phase(input logic [IDX_W-1:0] base, input logic [MAP_BYTES_W-1:0] bytes,
                            input int idle_pct, input int hold_pct, input int target);
      int first;
      settle();
      write_csr({REG_BASE_INDEX, 2'b00}, CSR_DW'(base));
      write_csr({REG_MAP_BYTES, 2'b00}, CSR_DW'(bytes));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      base_now = base;
      span = int'(bytes) * 8;
      if (span > MAP_BITS_DEF) span = MAP_BITS_DEF;
      sender_idle_pct = idle_pct;
      stall_pct = hold_pct;
      first = items_sent;
      while (items_sent - first < target) random_request();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset layout: base 0, all 1024 pages
      send_request(OP_TEST, 32'd0, 1'b0, '0);
      send_request(OP_TEST, 32'd1023, 1'b1, '1);
      send_request(OP_TEST, 32'd1024, 1'b0, '0);
      send_request(OP_TEST, 32'hFFFF_FFFF, 1'b0, '0);
      send_request(OP_WRITE, 32'd0, 1'b1, '1);
      send_request(OP_TEST, 32'd0, 1'b0, '0);
      send_request(OP_WRITE, 32'd1023, 1'b1, '0);
      send_request(OP_WRITE, 32'd1024, 1'b1, '0);
      send_request(OP_ALLOC, 32'd0, 1'b0, '0);
      send_request(OP_ALLOC, 32'd0, 1'b0, 11'd1);
      send_request(OP_ALLOC, 32'd0, 1'b0, 11'd1024);
      send_request(OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 11'd2047);
      // fills every free page between the two ends
      send_request(OP_ALLOC, 32'd0, 1'b0, 11'd1021);
      send_request(OP_ALLOC, 32'd0, 1'b0, 11'd1);
      send_request(OP_NONE, 32'hFFFF_FFFF, 1'b1, 11'd2047);
      send_request(OP_WRITE, 32'd0, 1'b0, '0);
      send_request(OP_WRITE, 32'd512, 1'b0, '0);
      send_request(OP_ALLOC, 32'd0, 1'b0, 11'd2);
      send_request(OP_ALLOC, 32'd0, 1'b0, 11'd1);
      send_request(OP_ALLOC, 32'd0, 1'b0, 11'd1);
      send_request(OP_TEST, 32'd512, 1'b0, '0);
      send_request(OP_WRITE, 32'hFFFF_FFFF, 1'b0, '0);

      run_phase(32'h0000_0000, 8'd128, 0, 0, 220);
      // starts wrap past the top of the index space; oversized byte count saturates
      run_phase(32'hFFFF_FF00, 8'd255, 54, 0, 200);
      run_phase(IDX_W'($urandom), 8'd1, 0, 54, 150);
      run_phase(32'hFFFF_FFFF, 8'd0, 21, 21, 60);
      run_phase(IDX_W'($urandom), MAP_BYTES_W'($urandom_range(128, 1)), 21, 21, 250);
      run_phase(32'h0000_0400, 8'd64, 0, 0, 250);

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[bitmap_first_fit_allocator] OK");
      end else begin
         $display("[bitmap_first_fit_allocator] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/bffa_pkg.sv
sv/bffa_ram.sv
sv/bitmap_first_fit_allocator.sv
test/bffa_checker.sv
test/tb.sv
